// ===== sv/interval_map_range_assign_defines.svh =====
// assertion macros for the interval map checker
// no dependencies
`ifndef INTERVAL_MAP_RANGE_ASSIGN_DEFINES_SVH
`define INTERVAL_MAP_RANGE_ASSIGN_DEFINES_SVH
// property that must hold whenever the block is out of reset
`define IMRA_ASSERT(lbl, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication whose consequent is checked in the next cycle
`define IMRA_ASSERT_NEXT(lbl, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== sv/imra_pkg.sv =====
// shared types and codes for the interval map block
// no dependencies
`timescale 1ns / 1ps
package imra_pkg;
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_ASSIGN = 1'b1;
	localparam int DATA_W = 80;
	localparam int OUT_W = 16;
endpackage

// ===== sv/imra_table.sv =====
// breakpoint table: two banks (live and scratch) in synchronous memories and the rewrite sequencer
// depends on imra_pkg
`timescale 1ns / 1ps
module imra_table #(
	parameter int CAPACITY = 64,
	parameter int KEY_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       func,
	input  logic [KEY_WIDTH-1:0]       kb,
	input  logic [KEY_WIDTH-1:0]       ke,
	input  logic [7:0]                 new_value,
	input  logic [7:0]                 default_value,
	output logic                       busy,
	output logic                       done,
	output logic [7:0]                 read_value,
	output logic [1:0]                 status
);
	import imra_pkg::*;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 3);
	localparam int EW = KEY_WIDTH + 8;

	// sequencer codes
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_EMIT = 3'd2;
	localparam logic [2:0] S_CHK  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	// bank bk_q is live, the other is the scratch for the rebuilt table
	logic [EW-1:0] mem0 [CAPACITY];
	logic [EW-1:0] mem1 [CAPACITY];
	logic          bk_q;
	logic [CW-1:0] cnt_q;
	logic [2:0]    st_q;
	logic          func_q;
	logic [KEY_WIDTH-1:0] kb_q, ke_q;
	logic [7:0]    val_q, carried_q;
	logic [CW-1:0] ri_q;     // read index into live bank
	logic          rv_q;     // read data valid
	logic [CW-1:0] n_q;      // entries written to scratch
	logic          bx_q;     // begin point already handled
	logic          ex_q;     // end point already handled
	logic [EW-1:0] rd0, rd1;
	logic          we;
	logic [AW-1:0] wa;
	logic [EW-1:0] wd;
	logic [AW-1:0] ra;
	logic [7:0]    rval_q;
	logic [1:0]    rst_q;
	logic          done_q;

	// memories: each read at one address, written at one
	always_ff @(posedge clk) begin
		if (we && bk_q) mem0[wa] <= wd;
		if (we && !bk_q) mem1[wa] <= wd;
		rd0 <= mem0[ra];
		rd1 <= mem1[ra];
	end

	logic [EW-1:0]        rd;
	logic [KEY_WIDTH-1:0] rk;
	logic [7:0]           rvv;
	assign rd  = bk_q ? rd1 : rd0;
	assign rk  = rd[EW-1:8];
	assign rvv = rd[7:0];
	assign ra  = ri_q[AW-1:0];

	logic lt_b, eq_b, le_e;
	assign lt_b = rk < kb_q;
	assign eq_b = rk == kb_q;
	assign le_e = rk <= ke_q;

	// write decision for one scan step over the live entries and for the emit step
	always_comb begin
		we = 1'b0;
		wa = n_q[AW-1:0];
		wd = '0;
		if (st_q == S_SCAN && rv_q && func_q && n_q < CW'(CAPACITY)) begin
			if (lt_b) begin
				we = 1'b1; wd = rd;
			end else if (!bx_q) begin
				if (eq_b || carried_q != val_q) begin
					we = 1'b1; wd = {kb_q, val_q};
				end
			end else if (le_e) begin
				we = 1'b0;
			end else if (!ex_q) begin
				if (carried_q != val_q) begin
					we = 1'b1; wd = {ke_q, carried_q};
				end
			end else begin
				we = 1'b1; wd = rd;
			end
		end else if (st_q == S_EMIT && n_q < CW'(CAPACITY)) begin
			if (!bx_q && carried_q != val_q) begin
				we = 1'b1; wd = {kb_q, val_q};
			end else if (bx_q && !ex_q && carried_q != val_q) begin
				we = 1'b1; wd = {ke_q, carried_q};
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; bk_q <= 1'b0; cnt_q <= '0; done_q <= 1'b0;
			rv_q <= 1'b0; ri_q <= '0; n_q <= '0; bx_q <= 1'b0; ex_q <= 1'b0;
			func_q <= 1'b0; kb_q <= '0; ke_q <= '0; val_q <= '0;
			carried_q <= '0; rval_q <= '0; rst_q <= ST_DONE;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (start) begin
						ri_q <= '0; rv_q <= 1'b0; n_q <= '0;
						bx_q <= 1'b0; ex_q <= 1'b0;
						if (func && !(kb < ke)) begin
							rst_q <= ST_EMPTY; rval_q <= '0; done_q <= 1'b1;
						end else begin
							st_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// issue read for index ri_q, consume previous
					if (!rv_q) begin
						if (ri_q < cnt_q) begin
							rv_q <= 1'b1;
						end else begin
							st_q <= func_q ? S_EMIT : S_FIN;
						end
					end else begin
						rv_q <= 1'b0;
						if (!func_q) begin
							if (rk <= kb_q) begin
								carried_q <= rvv; ri_q <= ri_q + 1'b1;
							end else begin
								st_q <= S_FIN;
							end
						end else begin
							if (we) n_q <= n_q + 1'b1;
							else if (n_q >= CW'(CAPACITY) && !(bx_q && le_e && !lt_b))
								n_q <= CW'(CAPACITY + 1);
							if (lt_b) begin
								carried_q <= rvv; ri_q <= ri_q + 1'b1;
							end else if (!bx_q) begin
								bx_q <= 1'b1;
								// breakpoint at begin is replaced, its value carries on
								if (eq_b) begin
									carried_q <= rvv; ri_q <= ri_q + 1'b1;
								end
							end else if (le_e) begin
								carried_q <= rvv; ri_q <= ri_q + 1'b1;
							end else if (!ex_q) begin
								ex_q <= 1'b1;
							end else begin
								ri_q <= ri_q + 1'b1;
							end
						end
					end
				end
				S_EMIT: begin
					if (we) n_q <= n_q + 1'b1;
					else if (n_q >= CW'(CAPACITY) && !ex_q && carried_q != val_q)
						n_q <= CW'(CAPACITY + 1);
					if (!bx_q) bx_q <= 1'b1;
					else begin
						ex_q <= 1'b1; st_q <= S_CHK;
					end
				end
				S_CHK: begin
					rval_q <= '0;
					if (n_q > CW'(CAPACITY)) rst_q <= ST_FULL;
					else begin
						rst_q <= ST_DONE; bk_q <= ~bk_q; cnt_q <= n_q;
					end
					done_q <= 1'b1; st_q <= S_IDLE;
				end
				S_FIN: begin
					rval_q <= carried_q; rst_q <= ST_DONE;
					done_q <= 1'b1; st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
			if (st_q == S_IDLE && start) begin
				func_q <= func; kb_q <= kb; ke_q <= ke; val_q <= new_value;
				carried_q <= default_value;
			end
		end
	end

	assign busy = st_q != S_IDLE;
	assign done = done_q;
	assign read_value = rval_q;
	assign status = rst_q;
endmodule

// ===== sv/interval_map_range_assign.sv =====
// interval map top level: stream ports, apb register, output register
// depends on imra_pkg, imra_table
//
// usage: one word on s_axis gives func, key_begin, key_end and new_value; the
// block answers with one word on m_axis holding read_value and status.
// a lookup walks the live table from the lowest breakpoint through the
// breakpoints at or below the key. an assign streams the whole table through
// the read-modify-write sequencer into the second memory bank, then swaps
// banks; a table that would overflow is dropped and the old bank stays live.
// an assign with an empty range answers with status empty and no table walk.
// one item is in work at a time, limited by the single read port.
// the result sits in an output register; while it waits the input stays
// closed, so a stalled receiver holds off the next word. reset empties the
// table (count zero), clears default_value and the output register; no memory
// sweep. default_value is at byte address 0 of the apb port.
`timescale 1ns / 1ps
module interval_map_range_assign #(
	parameter int CAPACITY = 64,
	parameter int KEY_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// func[0], key_begin[32:1], key_end[64:33], new_value[72:65], zeros
	input  logic [imra_pkg::DATA_W-1:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_value[7:0], status[9:8], zeros
	output logic [imra_pkg::OUT_W-1:0] m_axis_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import imra_pkg::*;
	logic [7:0] dflt_q;
	logic       busy, done, start, pend_q, ov_q;
	logic [7:0] rv;
	logic [1:0] st;
	logic [OUT_W-1:0] od_q;

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {24'd0, dflt_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dflt_q <= '0;
		else if (psel && penable && pwrite && paddr == 2'd0) dflt_q <= pwdata[7:0];
	end

	// keys wrapped to the configured width, sign bit flipped so unsigned compares give signed order
	logic [KEY_WIDTH-1:0] kb, ke;
	logic [63:0] kbx, kex;
	assign kbx = {{32{s_axis_tdata[32]}}, s_axis_tdata[32:1]};
	assign kex = {{32{s_axis_tdata[64]}}, s_axis_tdata[64:33]};
	assign kb = kbx[KEY_WIDTH-1:0] ^ (KEY_WIDTH'(1) << (KEY_WIDTH - 1));
	assign ke = kex[KEY_WIDTH-1:0] ^ (KEY_WIDTH'(1) << (KEY_WIDTH - 1));

	// accept only when sequencer idle and no result waits behind the output
	assign s_axis_tready = !busy && !pend_q && !done && !ov_q;
	assign start = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0; ov_q <= 1'b0;
		end else begin
			if (start) pend_q <= 1'b1;
			else if (done) pend_q <= 1'b0;
			if (done) ov_q <= 1'b1;
			else if (m_axis_tready) ov_q <= 1'b0;
		end
	end
	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) od_q <= '0;
		else if (done) od_q <= OUT_W'({st, rv});
	end
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = od_q;

	imra_table #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_table (
		.clk(clk), .arst_n(arst_n), .start(start),
		.func(s_axis_tdata[0]), .kb(kb), .ke(ke),
		.new_value(s_axis_tdata[72:65]), .default_value(dflt_q),
		.busy(busy), .done(done), .read_value(rv), .status(st)
	);
endmodule

// ===== sv/imra_checker.sv =====
// port-level checker for the interval map block, bound to the top level
// depends on interval_map_range_assign_defines.svh
`timescale 1ns / 1ps
`include "interval_map_range_assign_defines.svh"
module imra_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        pready
);
	logic take, stall, held, zero_ok;
	assign take = s_axis_tvalid && s_axis_tready;
	assign stall = m_axis_tvalid && !m_axis_tready;
	assign held = m_axis_tvalid && pready;
	assign zero_ok = m_axis_tdata[9:8] == 2'd0 || m_axis_tdata[7:0] == 8'd0;

	// status never takes the unused code
	`IMRA_ASSERT(a_status_code, arst_n, !m_axis_tvalid || m_axis_tdata[9:8] != 2'd3, "bad status")
	// results with a nonzero status carry zero value
	`IMRA_ASSERT(a_assign_zero, arst_n, !m_axis_tvalid || zero_ok, "nonzero value")
	// no new word taken while a result waits
	`IMRA_ASSERT(a_no_accept_pend, arst_n, !(m_axis_tvalid && s_axis_tready), "accept while held")
	// accepted word blocks the input next cycle
	`IMRA_ASSERT_NEXT(a_one_in_flight, arst_n, take, !s_axis_tready, "second word in flight")
	// held result stays
	`IMRA_ASSERT_NEXT(a_hold, arst_n, stall, held && $stable(m_axis_tdata), "result dropped")
endmodule

bind interval_map_range_assign imra_checker u_imra_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .pready(pready)
);
